FILE: rtl/core/cascaded_biquad_bandpass_macros.svh
// Assertion helpers used by the filter's controller RTL.
`ifndef CASCADED_BIQUAD_BANDPASS_MACROS_SVH
`define CASCADED_BIQUAD_BANDPASS_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define CBB_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Property that must hold in the cycle after its trigger.
`define CBB_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

FILE: rtl/core/cbb_pkg.sv
`timescale 1ns / 1ps

package cbb_pkg;

   localparam int SampleWidth   = 32;
   localparam int CoefWidth     = 32;
   localparam int AccWidth      = 64;
   localparam int CoefFracBits  = 30;
   localparam int TapCount      = 3;
   localparam int RegIndexWidth = 3;
   localparam int TermWidth     = 4;

   // Configuration register indexes.
   localparam logic [RegIndexWidth-1:0] RegCoefA0 = 3'd0;
   localparam logic [RegIndexWidth-1:0] RegCoefA1 = 3'd1;
   localparam logic [RegIndexWidth-1:0] RegCoefA2 = 3'd2;
   localparam logic [RegIndexWidth-1:0] RegCoefB1 = 3'd3;
   localparam logic [RegIndexWidth-1:0] RegCoefB2 = 3'd4;

   // Product terms, numbered in the order the controller issues them.
   // Section two takes its current-input term last, once section one is done.
   localparam logic [TermWidth-1:0] TermA0X   = 4'd0;
   localparam logic [TermWidth-1:0] TermA1X1  = 4'd1;
   localparam logic [TermWidth-1:0] TermA2X2  = 4'd2;
   localparam logic [TermWidth-1:0] TermB1Y11 = 4'd3;
   localparam logic [TermWidth-1:0] TermB2Y12 = 4'd4;
   localparam logic [TermWidth-1:0] TermA1Y11 = 4'd5;
   localparam logic [TermWidth-1:0] TermA2Y12 = 4'd6;
   localparam logic [TermWidth-1:0] TermB1Y21 = 4'd7;
   localparam logic [TermWidth-1:0] TermB2Y22 = 4'd8;
   localparam logic [TermWidth-1:0] TermA0Y1  = 4'd9;

   localparam logic [SampleWidth-1:0] SatMax = {1'b0, {(SampleWidth-1){1'b1}}};
   localparam logic [SampleWidth-1:0] SatMin = {1'b1, {(SampleWidth-1){1'b0}}};

   typedef struct packed {
      logic                 sample_load;  // capture the request sample
      logic [TermWidth-1:0] term;         // operands for the multiplier
      logic                 acc_load;     // accumulator takes the product
      logic                 acc_add;      // accumulator adds the product
      logic                 y1_latch;     // section one result is complete
      logic                 finish;       // load output, advance histories
   } cbb_cmd_type;

endpackage

FILE: rtl/core/cascaded_biquad_bandpass.sv
// A request is accepted only while the controller is idle, so the next one is taken
// once the previous one has finished; the single shared 32x32 multiply-accumulate
// unit computes all ten products in turn.
// The response waits in an output register while the next request is taken.
// Reset (synchronous, active high) clears coefficients, histories and valids.
`timescale 1ns / 1ps

module cascaded_biquad_bandpass (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [cbb_pkg::SampleWidth-1:0] req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [cbb_pkg::SampleWidth-1:0] rsp_sample_out,
   input  logic                                   csr_wr_en,
   input  logic [cbb_pkg::RegIndexWidth-1:0]      csr_index,
   input  logic [cbb_pkg::CoefWidth-1:0]          csr_wdata
);

   cbb_pkg::cbb_cmd_type cmd;

   cbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cbb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

FILE: rtl/core/cbb_ctrl.sv
`timescale 1ns / 1ps
`include "cascaded_biquad_bandpass_macros.svh"

module cbb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cbb_pkg::cbb_cmd_type cmd
);

   localparam logic StIdle = 1'b0;
   localparam logic StRun  = 1'b1;

   localparam logic [3:0] StepAccLoad1 = 4'd1;
   localparam logic [3:0] StepAccLoad2 = 4'd6;
   localparam logic [3:0] StepLastMul  = 4'd9;
   localparam logic [3:0] StepLastAcc  = 4'd10;
   localparam logic [3:0] StepFinish   = 4'd11;

   logic       state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd             = '0;
      cmd.sample_load = accept;
      // The step number doubles as the term code while products are issued.
      cmd.term        = (step_ff <= StepLastMul) ? step_ff[cbb_pkg::TermWidth-1:0]
                                                 : cbb_pkg::TermA0X;
      if (state_ff == StRun) begin
         cmd.acc_load = (step_ff == StepAccLoad1) || (step_ff == StepAccLoad2);
         cmd.acc_add  = (step_ff > StepAccLoad1) && (step_ff <= StepLastAcc) &&
                        (step_ff != StepAccLoad2);
         cmd.y1_latch = (step_ff == StepAccLoad2);
         cmd.finish   = (step_ff == StepFinish) && slot_free;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StRun;
               step_in  = '0;
            end
         end
         StRun: begin
            if (step_ff != StepFinish) begin
               step_in = step_ff + 4'd1;
            end else if (slot_free) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CBB_ASSERT_SAME(a_finish_slot, clock, reset, cmd.finish, (!rsp_valid_ff || rsp_ready), "result overwrites an untaken response")
   `CBB_ASSERT_NEXT(a_accept_starts, clock, reset, accept, (state_ff == StRun && step_ff == 4'd0), "accepted request did not start the schedule")
   `CBB_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, (rsp_valid_ff && state_ff == StIdle), "finished request left no response")

endmodule

FILE: rtl/core/cbb_datapath.sv
`timescale 1ns / 1ps

module cbb_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_wr_en,
   input  logic [cbb_pkg::RegIndexWidth-1:0]         csr_index,
   input  logic [cbb_pkg::CoefWidth-1:0]             csr_wdata,
   input  cbb_pkg::cbb_cmd_type                      cmd,
   input  logic signed [cbb_pkg::SampleWidth-1:0]    req_sample_in,
   output logic signed [cbb_pkg::SampleWidth-1:0]    rsp_sample_out
);

   localparam int SW = cbb_pkg::SampleWidth;
   localparam int CW = cbb_pkg::CoefWidth;
   localparam int AW = cbb_pkg::AccWidth;

   logic signed [CW-1:0] coef_a0_ff, coef_a0_in;
   logic signed [CW-1:0] coef_a1_ff, coef_a1_in;
   logic signed [CW-1:0] coef_a2_ff, coef_a2_in;
   logic signed [CW-1:0] coef_b1_ff, coef_b1_in;
   logic signed [CW-1:0] coef_b2_ff, coef_b2_in;

   logic signed [SW-1:0] x_ff, x_in;
   logic signed [SW-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [SW-1:0] y11_ff, y11_in, y12_ff, y12_in;
   logic signed [SW-1:0] y21_ff, y21_in, y22_ff, y22_in;
   logic signed [SW-1:0] y1_ff, y1_in;
   logic signed [SW-1:0] out_ff, out_in;

   logic signed [CW-1:0] op_coef;
   logic signed [SW-1:0] op_data;
   logic signed [AW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] acc_shift;
   logic [AW-SW:0]       acc_upper;
   logic [SW-1:0]        sat_value;

   always_comb begin
      coef_a0_in = coef_a0_ff;
      coef_a1_in = coef_a1_ff;
      coef_a2_in = coef_a2_ff;
      coef_b1_in = coef_b1_ff;
      coef_b2_in = coef_b2_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cbb_pkg::RegCoefA0: coef_a0_in = csr_wdata;
            cbb_pkg::RegCoefA1: coef_a1_in = csr_wdata;
            cbb_pkg::RegCoefA2: coef_a2_in = csr_wdata;
            cbb_pkg::RegCoefB1: coef_b1_in = csr_wdata;
            cbb_pkg::RegCoefB2: coef_b2_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.term)
         cbb_pkg::TermA0X:   begin op_coef = coef_a0_ff; op_data = x_ff;   end
         cbb_pkg::TermA1X1:  begin op_coef = coef_a1_ff; op_data = x1_ff;  end
         cbb_pkg::TermA2X2:  begin op_coef = coef_a2_ff; op_data = x2_ff;  end
         cbb_pkg::TermB1Y11: begin op_coef = coef_b1_ff; op_data = y11_ff; end
         cbb_pkg::TermB2Y12: begin op_coef = coef_b2_ff; op_data = y12_ff; end
         cbb_pkg::TermA1Y11: begin op_coef = coef_a1_ff; op_data = y11_ff; end
         cbb_pkg::TermA2Y12: begin op_coef = coef_a2_ff; op_data = y12_ff; end
         cbb_pkg::TermB1Y21: begin op_coef = coef_b1_ff; op_data = y21_ff; end
         cbb_pkg::TermB2Y22: begin op_coef = coef_b2_ff; op_data = y22_ff; end
         cbb_pkg::TermA0Y1:  begin op_coef = coef_a0_ff; op_data = y1_ff;  end
         default:            begin op_coef = coef_a0_ff; op_data = x_ff;   end
      endcase
   end

   assign prod_in = AW'(op_coef) * AW'(op_data);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_load) begin
         acc_in = prod_ff;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   // The accumulator wraps; the shifted sum saturates when its upper bits
   // are not all copies of the result's sign bit.
   assign acc_shift = acc_ff >>> cbb_pkg::CoefFracBits;
   assign acc_upper = acc_shift[AW-1:SW-1];
   assign sat_value = ((&acc_upper) || !(|acc_upper)) ? acc_shift[SW-1:0] :
                      (acc_shift[AW-1] ? cbb_pkg::SatMin : cbb_pkg::SatMax);

   always_comb begin
      x_in   = cmd.sample_load ? req_sample_in : x_ff;
      y1_in  = cmd.y1_latch ? signed'(sat_value) : y1_ff;
      out_in = out_ff;
      x1_in  = x1_ff;
      x2_in  = x2_ff;
      y11_in = y11_ff;
      y12_in = y12_ff;
      y21_in = y21_ff;
      y22_in = y22_ff;
      if (cmd.finish) begin
         out_in = signed'(sat_value);
         x1_in  = x_ff;
         x2_in  = x1_ff;
         y11_in = y1_ff;
         y12_in = y11_ff;
         y21_in = signed'(sat_value);
         y22_in = y21_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a0_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         x1_ff      <= '0;
         x2_ff      <= '0;
         y11_ff     <= '0;
         y12_ff     <= '0;
         y21_ff     <= '0;
         y22_ff     <= '0;
      end else begin
         coef_a0_ff <= coef_a0_in;
         coef_a1_ff <= coef_a1_in;
         coef_a2_ff <= coef_a2_in;
         coef_b1_ff <= coef_b1_in;
         coef_b2_ff <= coef_b2_in;
         x1_ff      <= x1_in;
         x2_ff      <= x2_in;
         y11_ff     <= y11_in;
         y12_ff     <= y12_in;
         y21_ff     <= y21_in;
         y22_ff     <= y22_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y1_ff   <= y1_in;
      out_ff  <= out_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign rsp_sample_out = out_ff;

endmodule
